[rtl/cpq_pkg.sv]
// Package for the coin pulse qualifier and repeater: tick constants, register
// map, config/item/result structs and the tick-to-millisecond helpers.
// No dependencies.
`timescale 1ns / 1ps

package cpq_pkg;

    // milliseconds per qualifier tick and per output tick
    localparam int IN_TICK_MS  = 10;
    localparam int OUT_TICK_MS = 10;

    // counter widths
    localparam int CNT_W = 16;
    localparam int GAP_W = 8;

    // widths of the tick counts scaled to milliseconds
    localparam int IN_MW  = CNT_W + $clog2(IN_TICK_MS + 1);
    localparam int GAP_MW = GAP_W + $clog2(IN_TICK_MS + 1);
    localparam int OUT_MW = CNT_W + $clog2(OUT_TICK_MS + 1) + 1;

    // register map
    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = $clog2(NUM_REGS * 4);
    localparam int IDX_W    = ADDR_W - 2;
    localparam int DATA_W   = 32;

    typedef enum logic [IDX_W-1:0] {
        REG_NC       = 3'd0,
        REG_IN_MIN   = 3'd1,
        REG_IN_MAX   = 3'd2,
        REG_OUT_W    = 3'd3,
        REG_OUT_S    = 3'd4,
        REG_MAX_PEND = 3'd5
    } t_reg_idx;

    // register reset values
    localparam logic             RST_NC       = 1'b0;
    localparam logic [CNT_W-1:0] RST_IN_MIN   = 16'd25;
    localparam logic [CNT_W-1:0] RST_IN_MAX   = 16'd1000;
    localparam logic [CNT_W-1:0] RST_OUT_W    = 16'd50;
    localparam logic [CNT_W-1:0] RST_OUT_S    = 16'd100;
    localparam logic [CNT_W-1:0] RST_MAX_PEND = 16'd100;

    typedef struct packed {
        logic             nc;
        logic [CNT_W-1:0] in_min;
        logic [CNT_W-1:0] in_max;
        logic [CNT_W-1:0] out_w;
        logic [CNT_W-1:0] out_s;
        logic [CNT_W-1:0] max_pend;
    } t_cfg;

    typedef struct packed {
        logic       in_tick;
        logic       out_tick;
        logic       coin_level;
        logic [7:0] scan_add;
    } t_item;

    typedef struct packed {
        logic             out_pin;
        logic [CNT_W-1:0] coins_waiting;
        logic [CNT_W-1:0] scans_waiting;
        logic [CNT_W-1:0] coins_replayed;
        logic [CNT_W-1:0] scans_replayed;
        logic             coin_accepted;
        logic [CNT_W-1:0] last_width_ms;
        logic             input_is_closed;
    } t_res;

    // increment that sticks at all ones
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [IN_MW-1:0] in_ms(input logic [CNT_W-1:0] v);
        return IN_MW'(v) * IN_MW'(IN_TICK_MS);
    endfunction

    function automatic logic [GAP_MW-1:0] gap_ms(input logic [GAP_W-1:0] v);
        return GAP_MW'(v) * GAP_MW'(IN_TICK_MS);
    endfunction

    function automatic logic [OUT_MW-1:0] out_ms(input logic [CNT_W-1:0] v);
        return OUT_MW'(v) * OUT_MW'(OUT_TICK_MS);
    endfunction

endpackage

[rtl/cpq_in_if.sv]
// Input item channel of the coin pulse qualifier: valid/ready plus item fields.
// Depends on cpq_pkg.
`timescale 1ns / 1ps

interface cpq_in_if;
    import cpq_pkg::*;

    logic       valid;
    logic       ready;
    logic       in_tick;
    logic       out_tick;
    logic       coin_level;
    logic [7:0] scan_add;

    modport source (output valid, output in_tick, output out_tick, output coin_level,
                    output scan_add, input ready);
    modport sink   (input valid, input in_tick, input out_tick, input coin_level,
                    input scan_add, output ready);
endinterface

[rtl/cpq_out_if.sv]
// Result channel of the coin pulse qualifier: valid/ready plus result fields.
// Depends on cpq_pkg.
`timescale 1ns / 1ps

interface cpq_out_if;
    import cpq_pkg::*;

    logic             valid;
    logic             ready;
    logic             out_pin;
    logic [CNT_W-1:0] coins_waiting;
    logic [CNT_W-1:0] scans_waiting;
    logic [CNT_W-1:0] coins_replayed;
    logic [CNT_W-1:0] scans_replayed;
    logic             coin_accepted;
    logic [CNT_W-1:0] last_width_ms;
    logic             input_is_closed;

    modport source (output valid, output out_pin, output coins_waiting,
                    output scans_waiting, output coins_replayed, output scans_replayed,
                    output coin_accepted, output last_width_ms, output input_is_closed,
                    input ready);
    modport sink   (input valid, input out_pin, input coins_waiting,
                    input scans_waiting, input coins_replayed, input scans_replayed,
                    input coin_accepted, input last_width_ms, input input_is_closed,
                    output ready);
endinterface

[rtl/coin_pulse_qualifier_and_repeater.sv]
// Channel    Dir  Handshake       Contents
// i_in       in   valid/ready     in_tick, out_tick, coin_level, scan_add
// o_out      out  valid/ready     pin level, pending and replay counts, status
// cfg (APB)  in   psel/penable    six config registers at byte address 4*i
//
// One item per cycle while the result is taken; each item passes the input
// register, then the update logic into the result register.
// The state update of one item is a single pass through cpq_core, so the
// next item sees its state when it moves on.
// A stalled result holds in the output register; the input register still
// takes one more item, then ready drops until the result is taken.
// Synchronous active-low reset clears state, valids and the result register.
//
// Top level of the coin pulse qualifier and repeater.
// Depends on cpq_pkg, cpq_in_if, cpq_out_if, cpq_regs and cpq_core.
`timescale 1ns / 1ps

module coin_pulse_qualifier_and_repeater (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cpq_in_if.sink                        i_in,
    cpq_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpq_pkg::ADDR_W-1:0]    paddr,
    input  logic [cpq_pkg::DATA_W-1:0]    pwdata,
    output logic [cpq_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import cpq_pkg::*;

    t_cfg  w_cfg;
    t_item r_item;
    logic  r_in_vld;
    t_res  w_res;
    t_res  r_res;
    logic  r_out_vld;
    logic  w_adv;

    cpq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // item in the input register moves on when the result register is free
    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;

    cpq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.in_tick    <= i_in.in_tick;
            r_item.out_tick   <= i_in.out_tick;
            r_item.coin_level <= i_in.coin_level;
            r_item.scan_add   <= i_in.scan_add;
        end
    end

    // valids and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_res     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_res     <= w_res;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.out_pin         = r_res.out_pin;
    assign o_out.coins_waiting   = r_res.coins_waiting;
    assign o_out.scans_waiting   = r_res.scans_waiting;
    assign o_out.coins_replayed  = r_res.coins_replayed;
    assign o_out.scans_replayed  = r_res.scans_replayed;
    assign o_out.coin_accepted   = r_res.coin_accepted;
    assign o_out.last_width_ms   = r_res.last_width_ms;
    assign o_out.input_is_closed = r_res.input_is_closed;

`ifndef SYNTHESIS
    // a waiting item is never dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_adv |=> r_in_vld)
        else $error("input register lost an item while stalled");

    // the result only changes when an item moves through
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> r_res == $past(r_res))
        else $error("result changed without an item transfer");

    // one item completes at most one replayed pulse
    a_one_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> !((o_out.coins_replayed != $past(o_out.coins_replayed))
                 && (o_out.scans_replayed != $past(o_out.scans_replayed))))
        else $error("coin and scan replay counts moved on the same item");
`endif

endmodule

[rtl/cpq_regs.sv]
// APB-style configuration registers of the coin pulse qualifier.
// Depends on cpq_pkg.
`timescale 1ns / 1ps

module cpq_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpq_pkg::ADDR_W-1:0]    paddr,
    input  logic [cpq_pkg::DATA_W-1:0]    pwdata,
    output logic [cpq_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output cpq_pkg::t_cfg                 o_cfg
);
    import cpq_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes, out-of-map indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nc       <= RST_NC;
            r_cfg.in_min   <= RST_IN_MIN;
            r_cfg.in_max   <= RST_IN_MAX;
            r_cfg.out_w    <= RST_OUT_W;
            r_cfg.out_s    <= RST_OUT_S;
            r_cfg.max_pend <= RST_MAX_PEND;
        end else if (w_wr) begin
            case (w_idx)
                REG_NC:       r_cfg.nc       <= pwdata[0];
                REG_IN_MIN:   r_cfg.in_min   <= pwdata[CNT_W-1:0];
                REG_IN_MAX:   r_cfg.in_max   <= pwdata[CNT_W-1:0];
                REG_OUT_W:    r_cfg.out_w    <= pwdata[CNT_W-1:0];
                REG_OUT_S:    r_cfg.out_s    <= pwdata[CNT_W-1:0];
                REG_MAX_PEND: r_cfg.max_pend <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_NC:       prdata = DATA_W'(r_cfg.nc);
            REG_IN_MIN:   prdata = DATA_W'(r_cfg.in_min);
            REG_IN_MAX:   prdata = DATA_W'(r_cfg.in_max);
            REG_OUT_W:    prdata = DATA_W'(r_cfg.out_w);
            REG_OUT_S:    prdata = DATA_W'(r_cfg.out_s);
            REG_MAX_PEND: prdata = DATA_W'(r_cfg.max_pend);
            default:      prdata = '0;
        endcase
    end

endmodule

[rtl/cpq_core.sv]
// Qualifier and repeater state with its one-item update logic.
// Depends on cpq_pkg.
`timescale 1ns / 1ps

module cpq_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  cpq_pkg::t_item i_item,
    input  cpq_pkg::t_cfg  i_cfg,
    output cpq_pkg::t_res  o_res
);
    import cpq_pkg::*;

    // state
    logic             r_started, n_started;
    logic             r_pol, n_pol;
    logic             r_pulse, n_pulse;
    logic [CNT_W-1:0] r_width, n_width;
    logic [GAP_W-1:0] r_gap, n_gap;
    logic [CNT_W-1:0] r_coins, n_coins;
    logic [CNT_W-1:0] r_scans, n_scans;
    logic [CNT_W-1:0] r_phase, n_phase;
    logic             r_pin, n_pin;
    logic [CNT_W-1:0] r_coin_rep, n_coin_rep;
    logic [CNT_W-1:0] r_scan_rep, n_scan_rep;
    logic [CNT_W-1:0] r_acc_w, n_acc_w;

    // working values
    logic              w_accepted;
    logic              w_active;
    logic [CNT_W:0]    w_scan_sum;
    logic [IN_MW-1:0]  w_ms;
    logic              w_sel;
    logic [CNT_W-1:0]  w_cnt;
    logic [OUT_MW-1:0] w_t;
    logic              w_done;
    logic              w_act_lvl;

    // one item: scan credit add, qualifier tick, then output tick
    always_comb begin
        n_started  = r_started;
        n_pol      = r_pol;
        n_pulse    = r_pulse;
        n_width    = r_width;
        n_gap      = r_gap;
        n_coins    = r_coins;
        n_phase    = r_phase;
        n_pin      = r_pin;
        n_coin_rep = r_coin_rep;
        n_scan_rep = r_scan_rep;
        n_acc_w    = r_acc_w;
        w_accepted = 1'b0;
        w_active   = 1'b0;
        w_ms       = '0;
        w_sel      = 1'b0;
        w_cnt      = '0;
        w_t        = '0;
        w_done     = 1'b0;
        w_act_lvl  = !i_cfg.nc;

        // saturating scan credit add
        w_scan_sum = {1'b0, r_scans} + (CNT_W + 1)'(i_item.scan_add);
        n_scans    = w_scan_sum[CNT_W] ? '1 : w_scan_sum[CNT_W-1:0];

        // input qualifier tick
        if (i_item.in_tick) begin
            if (!r_started) begin
                n_started = 1'b1;
                n_pol     = i_cfg.nc;
            end
            w_active = (i_item.coin_level == n_pol);
            if (w_active && !n_pulse) begin
                n_gap   = '0;
                n_width = '0;
                n_pulse = 1'b1;
            end else if (!w_active && n_pulse) begin
                n_pulse = 1'b0;
            end
            if (n_pulse) begin
                n_width = sat_inc(n_width);
                // overlong pulse: polarity was wrong
                if (in_ms(n_width) > IN_MW'(i_cfg.in_max)) begin
                    n_pol   = !n_pol;
                    n_gap   = '0;
                    n_width = '0;
                    n_pulse = 1'b0;
                end
            end else begin
                w_ms = in_ms(n_width);
                if (w_ms > IN_MW'(i_cfg.in_min) && w_ms < IN_MW'(i_cfg.in_max)
                    && n_gap != '1) begin
                    n_gap = n_gap + 1'b1;
                end
                // compare at full minimum width, a minimum of 2550 ms or more is never reached
                if (IN_MW'(gap_ms(n_gap)) > IN_MW'(i_cfg.in_min)) begin
                    n_acc_w    = (w_ms > IN_MW'({CNT_W{1'b1}})) ? '1 : w_ms[CNT_W-1:0];
                    n_coins    = sat_inc(n_coins);
                    n_gap      = '0;
                    n_width    = '0;
                    w_accepted = 1'b1;
                end
            end
        end

        // output tick: scans first, then coins, sharing one phase count; a count above max_pend is cleared
        if (i_item.out_tick && (n_scans != '0 || n_coins != '0)) begin
            w_sel = (n_scans != '0);
            w_cnt = w_sel ? n_scans : n_coins;
            if (w_cnt > i_cfg.max_pend) begin
                w_cnt = '0;
            end else begin
                n_phase = sat_inc(n_phase);
                w_t     = out_ms(n_phase);
                if (w_t <= OUT_MW'(i_cfg.out_w)) begin
                    n_pin = w_act_lvl;
                end else begin
                    n_pin = !w_act_lvl;
                    if (w_t > OUT_MW'(i_cfg.out_w) + OUT_MW'(i_cfg.out_s)) begin
                        n_phase = '0;
                        w_cnt   = w_cnt - 1'b1;
                        w_done  = 1'b1;
                    end
                end
            end
            if (w_sel) begin
                n_scans = w_cnt;
                if (w_done) begin
                    n_scan_rep = r_scan_rep + 1'b1;
                end
            end else begin
                n_coins = w_cnt;
                if (w_done) begin
                    n_coin_rep = r_coin_rep + 1'b1;
                end
            end
        end
    end

    // state registers, advanced once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_pol      <= 1'b0;
            r_pulse    <= 1'b0;
            r_width    <= '0;
            r_gap      <= '0;
            r_coins    <= '0;
            r_scans    <= '0;
            r_phase    <= '0;
            r_pin      <= 1'b0;
            r_coin_rep <= '0;
            r_scan_rep <= '0;
            r_acc_w    <= '0;
        end else if (i_step) begin
            r_started  <= n_started;
            r_pol      <= n_pol;
            r_pulse    <= n_pulse;
            r_width    <= n_width;
            r_gap      <= n_gap;
            r_coins    <= n_coins;
            r_scans    <= n_scans;
            r_phase    <= n_phase;
            r_pin      <= n_pin;
            r_coin_rep <= n_coin_rep;
            r_scan_rep <= n_scan_rep;
            r_acc_w    <= n_acc_w;
        end
    end

    // result of this item, taken after all updates
    assign o_res.out_pin         = n_pin;
    assign o_res.coins_waiting   = n_coins;
    assign o_res.scans_waiting   = n_scans;
    assign o_res.coins_replayed  = n_coin_rep;
    assign o_res.scans_replayed  = n_scan_rep;
    assign o_res.coin_accepted   = w_accepted;
    assign o_res.last_width_ms   = n_acc_w;
    assign o_res.input_is_closed = n_pol;

endmodule

[tb/cpq_status_checker.sv]
// Checker for the coin pulse qualifier and repeater: watches the item, status and
// register channels, keeps its own copy of the qualifier and replay state, compares.
// Depends on cpq_pkg, cpq_in_if and cpq_out_if.
`timescale 1ns / 1ps

module cpq_status_checker
    import cpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpq_in_if                 item_mon,
    cpq_out_if                status_mon,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                o_errors,
    output int                o_waiting,
    output int                o_checked,
    output int                o_coins
);

    localparam int MAX_REPORTS = 40;

    // register copy
    t_cfg cfg;

    // qualifier and repeater state
    logic        started;
    logic        in_pol;
    logic        in_pulse;
    logic [15:0] pulse_ticks;
    logic [7:0]  gap_ticks;
    logic [15:0] coins_pend;
    logic [15:0] scans_pend;
    logic [15:0] phase_ticks;
    logic        pin;
    logic [15:0] coin_reps;
    logic [15:0] scan_reps;
    logic [15:0] width_acc;

    t_res status_awaited[$];
    int   mismatches = 0;
    int   in_flight  = 0;
    int   checked    = 0;
    int   coins_seen = 0;

    assign o_errors  = mismatches;
    assign o_waiting = in_flight;
    assign o_checked = checked;
    assign o_coins   = coins_seen;

    // scan credit add, qualifier tick, then replay tick, as one item does
    function automatic t_res step_qualifier(input t_item it);
        t_res        r;
        logic [16:0] scan_sum;
        logic [31:0] width_ms;
        logic [31:0] phase_ms;
        logic        active;
        logic        accepted;
        logic        act_lvl;
        logic        served_scans;
        logic        pulse_done;
        logic [15:0] cnt;
        accepted = 1'b0;
        scan_sum = {1'b0, scans_pend} + 17'(it.scan_add);
        scans_pend = scan_sum[16] ? 16'hFFFF : scan_sum[15:0];

        // input qualifier
        if (it.in_tick) begin
            if (!started) begin
                started = 1'b1;
                in_pol  = cfg.nc;
            end
            active = (it.coin_level == in_pol);
            if (active && !in_pulse) begin
                gap_ticks   = '0;
                pulse_ticks = '0;
                in_pulse    = 1'b1;
            end else if (!active && in_pulse) begin
                in_pulse = 1'b0;
            end
            if (in_pulse) begin
                if (pulse_ticks != 16'hFFFF) pulse_ticks = pulse_ticks + 16'd1;
                // over-long pulse means the polarity guess was wrong
                if (32'(pulse_ticks) * 32'(IN_TICK_MS) > 32'(cfg.in_max)) begin
                    in_pol      = ~in_pol;
                    gap_ticks   = '0;
                    pulse_ticks = '0;
                    in_pulse    = 1'b0;
                end
            end else begin
                width_ms = 32'(pulse_ticks) * 32'(IN_TICK_MS);
                if (width_ms > 32'(cfg.in_min) && width_ms < 32'(cfg.in_max) &&
                    gap_ticks != 8'hFF) gap_ticks = gap_ticks + 8'd1;
                if (32'(gap_ticks) * 32'(IN_TICK_MS) > 32'(cfg.in_min)) begin
                    width_acc   = (width_ms > 32'hFFFF) ? 16'hFFFF : width_ms[15:0];
                    if (coins_pend != 16'hFFFF) coins_pend = coins_pend + 16'd1;
                    gap_ticks   = '0;
                    pulse_ticks = '0;
                    accepted    = 1'b1;
                end
            end
        end

        // output replay, scans before coins, phase count shared
        if (it.out_tick && (scans_pend != 0 || coins_pend != 0)) begin
            served_scans = (scans_pend != 0);
            cnt          = served_scans ? scans_pend : coins_pend;
            act_lvl      = ~cfg.nc;
            pulse_done   = 1'b0;
            if (cnt > cfg.max_pend) begin
                cnt = '0;
            end else begin
                if (phase_ticks != 16'hFFFF) phase_ticks = phase_ticks + 16'd1;
                phase_ms = 32'(phase_ticks) * 32'(OUT_TICK_MS);
                if (phase_ms <= 32'(cfg.out_w)) begin
                    pin = act_lvl;
                end else begin
                    pin = ~act_lvl;
                    if (phase_ms > 32'(cfg.out_w) + 32'(cfg.out_s)) begin
                        phase_ticks = '0;
                        cnt         = cnt - 16'd1;
                        pulse_done  = 1'b1;
                    end
                end
            end
            if (served_scans) begin
                scans_pend = cnt;
                if (pulse_done) scan_reps = scan_reps + 16'd1;
            end else begin
                coins_pend = cnt;
                if (pulse_done) coin_reps = coin_reps + 16'd1;
            end
        end

        r.out_pin         = pin;
        r.coins_waiting   = coins_pend;
        r.scans_waiting   = scans_pend;
        r.coins_replayed  = coin_reps;
        r.scans_replayed  = scan_reps;
        r.coin_accepted   = accepted;
        r.last_width_ms   = width_acc;
        r.input_is_closed = in_pol;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, fname, want, got);
        end
    endtask

    // all activity sampled at the rising edge
    always @(posedge i_clk) begin : watch
        t_res want;
        t_item it;
        if (!i_rst_n) begin
            cfg         = '{nc: RST_NC, in_min: RST_IN_MIN, in_max: RST_IN_MAX,
                            out_w: RST_OUT_W, out_s: RST_OUT_S, max_pend: RST_MAX_PEND};
            started     = 1'b0;
            in_pol      = 1'b0;
            in_pulse    = 1'b0;
            pulse_ticks = '0;
            gap_ticks   = '0;
            coins_pend  = '0;
            scans_pend  = '0;
            phase_ticks = '0;
            pin         = 1'b0;
            coin_reps   = '0;
            scan_reps   = '0;
            width_acc   = '0;
            status_awaited.delete();
        end else begin
            // status transfer against the oldest prediction
            if (status_mon.valid && status_mon.ready) begin
                if (status_awaited.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: status transfer with nothing expected", $time);
                end else begin
                    want = status_awaited.pop_front();
                    check_field("out_pin", 16'(want.out_pin), 16'(status_mon.out_pin));
                    check_field("coins_waiting", want.coins_waiting,
                                status_mon.coins_waiting);
                    check_field("scans_waiting", want.scans_waiting,
                                status_mon.scans_waiting);
                    check_field("coins_replayed", want.coins_replayed,
                                status_mon.coins_replayed);
                    check_field("scans_replayed", want.scans_replayed,
                                status_mon.scans_replayed);
                    check_field("coin_accepted", 16'(want.coin_accepted),
                                16'(status_mon.coin_accepted));
                    check_field("last_width_ms", want.last_width_ms,
                                status_mon.last_width_ms);
                    check_field("input_is_closed", 16'(want.input_is_closed),
                                16'(status_mon.input_is_closed));
                    checked++;
                    if (status_mon.coin_accepted === 1'b1) coins_seen++;
                end
            end

            // register write, masked to width, unknown index dropped
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_NC:       cfg.nc       = pwdata[0];
                    REG_IN_MIN:   cfg.in_min   = pwdata[15:0];
                    REG_IN_MAX:   cfg.in_max   = pwdata[15:0];
                    REG_OUT_W:    cfg.out_w    = pwdata[15:0];
                    REG_OUT_S:    cfg.out_s    = pwdata[15:0];
                    REG_MAX_PEND: cfg.max_pend = pwdata[15:0];
                    default: ;
                endcase
            end

            // item transfer
            if (item_mon.valid && item_mon.ready) begin
                it.in_tick    = item_mon.in_tick;
                it.out_tick   = item_mon.out_tick;
                it.coin_level = item_mon.coin_level;
                it.scan_add   = item_mon.scan_add;
                status_awaited.push_back(step_qualifier(it));
            end
        end
        in_flight = status_awaited.size();
    end

endmodule

[tb/tb_coin_pulse_qualifier_and_repeater.sv]
// Top of the coin pulse qualifier and repeater testbench: clock, reset, register
// settings, coin pulse and scan credit stimulus, stalls and the verdict.
// Depends on cpq_pkg, cpq_in_if, cpq_out_if, cpq_status_checker and the block.
`timescale 1ns / 1ps

module tb_coin_pulse_qualifier_and_repeater;
    import cpq_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int ITEM_TARGET  = 1550;
    localparam int TAIL_CYCLES  = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   errors;
    int   waiting;
    int   checked;
    int   coins;
    int   items_sent    = 0;
    int   settings_used = 0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   quiet_cycles  = 0;
    int   sh_min;
    int   sh_max;
    logic pol_hint = 1'b0;

    cpq_in_if  item_ch ();
    cpq_out_if status_ch ();

    coin_pulse_qualifier_and_repeater uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch.sink),
        .o_out   (status_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cpq_status_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .item_mon   (item_ch),
        .status_mon (status_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .o_errors   (errors),
        .o_waiting  (waiting),
        .o_checked  (checked),
        .o_coins    (coins)
    );

    always #6 i_clk = ~i_clk;

    // learned polarity as last reported, steers the coin pulse shapes
    always @(posedge i_clk) begin
        if (status_ch.valid && status_ch.ready) pol_hint <= status_ch.input_is_closed;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (status_ch.valid && status_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAIL coin_pulse_qualifier_and_repeater");
            $finish;
        end
    end

    // status receiver with random stalls
    initial begin
        forever begin
            @(negedge i_clk);
            status_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_item compose_item(input logic it_in, input logic it_out,
                                           input logic lvl, input logic [7:0] scan);
        t_item it;
        it.in_tick    = it_in;
        it.out_tick   = it_out;
        it.coin_level = lvl;
        it.scan_add   = scan;
        return it;
    endfunction

    // qualifier tick at a given level, scan credits now and then
    function automatic t_item tick_item(input logic lvl);
        int r;
        logic [7:0] scan;
        r = $urandom_range(99);
        if (r < 85)      scan = 8'd0;
        else if (r < 95) scan = 8'($urandom_range(1, 3));
        else             scan = 8'($urandom_range(255));
        return compose_item($urandom_range(9) != 0, $urandom_range(99) < 60, lvl, scan);
    endfunction

    // one item transfer, called and returning at a falling edge
    task automatic push_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.in_tick    <= it.in_tick;
        item_ch.out_tick   <= it.out_tick;
        item_ch.coin_level <= it.coin_level;
        item_ch.scan_add   <= it.scan_add;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // stop sending until every status has come back
    task automatic drain;
        item_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (waiting != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input int idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // new register setting while idle, junk in the unused upper bits, then an unmapped write
    task automatic apply_config(input logic nc, input int in_min, input int in_max,
                                input int out_w, input int out_s, input int max_pend);
        drain();
        repeat (4) @(negedge i_clk);
        apb_write(REG_NC, {31'($urandom), nc});
        apb_write(REG_IN_MIN, {16'($urandom), 16'(in_min)});
        apb_write(REG_IN_MAX, {16'($urandom), 16'(in_max)});
        apb_write(REG_OUT_W, {16'($urandom), 16'(out_w)});
        apb_write(REG_OUT_S, {16'($urandom), 16'(out_s)});
        apb_write(REG_MAX_PEND, {16'($urandom), 16'(max_pend)});
        apb_write(NUM_REGS + $urandom_range(1), $urandom);
        sh_min = in_min;
        sh_max = in_max;
        settings_used++;
    endtask

    // idle stretch, mostly valid pulse, then an idle gap mostly long enough to qualify
    task automatic feed_coin;
        int lo;
        int hi;
        int width_ticks;
        int gap;
        int lead;
        lo = sh_min / 10 + 1;
        hi = (sh_max > 0) ? (sh_max - 1) / 10 : 0;
        if (hi > lo + 6) hi = lo + 6;
        if (lo > hi || lo > 20) width_ticks = $urandom_range(1, 6);
        else                    width_ticks = $urandom_range(lo, hi);
        if ($urandom_range(9) == 0) width_ticks = width_ticks + $urandom_range(1, 3);
        gap = sh_min / 10 + 1;
        if (gap > 30) gap = $urandom_range(1, 5);
        else          gap = gap + $urandom_range(0, 2);
        if ($urandom_range(9) == 0) gap = $urandom_range(1, gap);
        lead = $urandom_range(0, 2);
        repeat (lead) push_item(tick_item(~pol_hint));
        repeat (width_ticks) push_item(tick_item(pol_hint));
        repeat (gap) push_item(tick_item(~pol_hint));
    endtask

    // one register setting with its idle mix, paused once halfway
    task automatic run_phase(input logic nc, input int in_min, input int in_max,
                             input int out_w, input int out_s, input int max_pend,
                             input int count, input bit flood);
        int first;
        bit paused;
        apply_config(nc, in_min, in_max, out_w, out_s, max_pend);
        case (settings_used % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 58; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
        endcase
        first  = items_sent;
        paused = 1'b0;
        while (items_sent - first < count) begin
            if (!paused && items_sent - first >= count / 2) begin
                drain();
                paused = 1'b1;
            end
            if (flood)
                push_item(compose_item($urandom_range(1), 1'b0, $urandom_range(1),
                                       8'(255 - $urandom_range(3))));
            else if ($urandom_range(99) < 75)
                feed_coin();
            else
                push_item(compose_item($urandom_range(1), $urandom_range(1),
                                       $urandom_range(1),
                                       $urandom_range(1) ? 8'($urandom_range(255)) : 8'd0));
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.in_tick    = 1'b0;
        item_ch.out_tick   = 1'b0;
        item_ch.coin_level = 1'b0;
        item_ch.scan_add   = 8'd0;
        status_ch.ready    = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sh_min             = int'(RST_IN_MIN);
        sh_max             = int'(RST_IN_MAX);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: idle item, big scan burst cleared, first tick loads polarity
        push_item(compose_item(1'b0, 1'b0, 1'b0, 8'd0));
        push_item(compose_item(1'b0, 1'b1, 1'b1, 8'd255));
        push_item(compose_item(1'b1, 1'b0, 1'b1, 8'd0));
        push_item(compose_item(1'b0, 1'b1, 1'b0, 8'd5));

        // output polarity change after the first tick, small limit
        apply_config(1'b1, 20, 40, 10, 0, 2);
        // valid three-tick pulse and gap gives one coin
        repeat (3) push_item(compose_item(1'b1, 1'b1, 1'b0, 8'd0));
        repeat (3) push_item(compose_item(1'b1, 1'b1, 1'b1, 8'd0));
        // over-long pulse flips the learned polarity
        repeat (5) push_item(compose_item(1'b1, 1'b0, 1'b0, 8'd0));
        push_item(compose_item(1'b1, 1'b1, 1'b1, 8'd128));
        push_item(compose_item(1'b0, 1'b1, 1'b0, 8'd1));
        repeat (4) push_item(compose_item(1'b0, 1'b1, 1'b1, 8'd0));

        // short pulses and spacing
        run_phase(1'b0, 20, 60, 10, 10, 100, 200, 1'b0);
        // widest acceptance window, zero-length output pulses, largest limit
        run_phase(1'b1, 0, 65535, 0, 0, 65535, 160, 1'b0);
        // scan credits saturate the pending count
        run_phase(1'b0, 20, 60, 0, 0, 65535, 270, 1'b1);
        // zero limit clears whatever is served
        run_phase(1'b1, 10, 50, 20, 10, 0, 120, 1'b0);
        // minimum not below maximum, no coin qualifies
        run_phase(1'b0, 500, 400, 10, 10, 3, 80, 1'b0);
        // gap can never exceed the minimum, output pulse never ends
        run_phase(1'b1, 2550, 65535, 65535, 65535, 5, 80, 1'b0);
        // zero maximum, every pulse flips the polarity
        run_phase(1'b0, 0, 0, 30, 20, 4, 80, 1'b0);
        // random small settings until the item budget is used
        while (items_sent < ITEM_TARGET) begin
            run_phase($urandom_range(1), $urandom_range(0, 60), $urandom_range(0, 160),
                      $urandom_range(0, 40), $urandom_range(0, 40),
                      $urandom_range(3) == 0 ? 100 : $urandom_range(0, 9), 150, 1'b0);
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d items under %0d register settings, all idle and stall mixes",
                 items_sent, settings_used);
        $display("%0d status transfers checked, %0d coins qualified", checked, coins);
        if (errors == 0 && waiting == 0) begin
            $display("PASS coin_pulse_qualifier_and_repeater");
        end else begin
            $display("FAIL coin_pulse_qualifier_and_repeater");
        end
        $finish;
    end

endmodule
